// File: rtl/bspl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the BSP point location block.
// No dependencies.
package bspl_pkg;

    localparam int unsigned MAX_NODES      = 8192;
    localparam int unsigned MAX_SUBSECTORS = 32768;
    localparam int unsigned NODE_AW        = $clog2(MAX_NODES);
    localparam int unsigned STEP_W         = $clog2(MAX_NODES + 1);
    localparam int unsigned CNT_W          = 14;
    localparam int unsigned Q_DEPTH        = 2;

    typedef struct packed {
        logic               mode;
        logic [12:0]        node_index;
        logic signed [31:0] part_x;
        logic signed [31:0] part_y;
        logic signed [31:0] part_dx;
        logic signed [31:0] part_dy;
        logic               front_is_leaf;
        logic [14:0]        front_index;
        logic               back_is_leaf;
        logic [14:0]        back_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in;

    typedef struct packed {
        logic [14:0] subsector_index;
        logic [13:0] steps_taken;
        logic        loop_error;
    } t_out;

    // Node table entry; child halves are {leaf flag, 15-bit index}.
    typedef struct packed {
        logic [15:0]        back;
        logic [15:0]        front;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_node;

    localparam int unsigned NODE_W = $bits(t_node);

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_QUERY = 2'd1,
        K_EMPTY = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [NODE_AW-1:0] addr;
        t_node              node;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_cmd;

endpackage

// File: rtl/bspl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bspl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/bspl_front.sv
`timescale 1ns / 1ps
// Front end: input register, node_count register and transaction classification.
// Depends on bspl_pkg.
module bspl_front
    import bspl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    output logic             o_push,
    output t_cmd             o_push_data,
    input  logic             i_q_full
);

    logic             r_valid;
    logic             n_valid;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic [CNT_W-1:0] r_node_count;
    logic [CNT_W-1:0] root;
    logic             accept;
    logic             keep;

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_push_data = r_cmd;
    assign root       = r_node_count - CNT_W'(1);

    always_comb begin
        n_cmd.node.x     = i_in_data.part_x;
        n_cmd.node.y     = i_in_data.part_y;
        n_cmd.node.dx    = i_in_data.part_dx;
        n_cmd.node.dy    = i_in_data.part_dy;
        n_cmd.node.front = {i_in_data.front_is_leaf, i_in_data.front_index};
        n_cmd.node.back  = {i_in_data.back_is_leaf, i_in_data.back_index};
        n_cmd.px         = i_in_data.point_x;
        n_cmd.py         = i_in_data.point_y;
        keep             = 1'b1;
        if (!i_in_data.mode) begin
            n_cmd.kind = K_WRITE;
            n_cmd.addr = i_in_data.node_index[NODE_AW-1:0];
            keep       = (32'(i_in_data.node_index) < MAX_NODES);
        end else if (r_node_count == '0) begin
            n_cmd.kind = K_EMPTY;
            n_cmd.addr = root[NODE_AW-1:0];
        end else begin
            n_cmd.kind = K_QUERY;
            n_cmd.addr = root[NODE_AW-1:0];
        end
        n_valid = (accept && keep) || (r_valid && i_q_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_node_count <= '0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_wr_en) begin
                r_node_count <= i_cfg_wr_data;
            end
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: rtl/bspl_queue.sv
`timescale 1ns / 1ps
// Short transaction queue between the front end and the tree walker.
// Depends on bspl_pkg.
module bspl_queue
    import bspl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_cmd           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic [QAW-1:0] n_wp;
    logic [QAW-1:0] n_rp;

    assign o_full  = (r_cnt == QCW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign n_wp    = (r_wp == QAW'(Q_DEPTH - 1)) ? '0 : r_wp + QAW'(1);
    assign n_rp    = (r_rp == QAW'(Q_DEPTH - 1)) ? '0 : r_rp + QAW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

// File: rtl/bspl_back.sv
`timescale 1ns / 1ps
// Back end: node table writes and the tree walk, one node per pass through states S_T1, S_T2 and S_T3.
// Depends on bspl_pkg and bspl_ram.
module bspl_back
    import bspl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_head,
    input  logic i_empty,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_T1,
        S_T2,
        S_T3,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;
    t_out                r_res, n_res;
    logic signed [31:0]  r_px, n_px, r_py, n_py;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic signed [31:0]  r_ox, n_ox, r_oy, n_oy;
    logic signed [15:0]  r_dxh, n_dxh, r_dyh, n_dyh;
    logic [31:0]         r_ch, n_ch;
    logic                r_early, n_early, r_eside, n_eside;
    logic signed [47:0]  r_left, n_left, r_right, n_right;

    logic               wr_en;
    logic               rd_en;
    logic [NODE_AW-1:0] rd_addr;
    logic [NODE_W-1:0]  rd_data;
    t_node              nd;
    logic signed [31:0] ox, oy;
    logic               side;
    logic [15:0]        child;
    logic [STEP_W-1:0]  steps_inc;
    logic               out_free;

    bspl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_head.addr),
        .i_wr_data (i_head.node),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign nd        = t_node'(rd_data);
    assign ox        = r_px - nd.x;
    assign oy        = r_py - nd.y;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign steps_inc = r_steps + STEP_W'(1);
    assign side      = r_early ? r_eside
                               : !($signed(r_right[47:16]) < $signed(r_left[47:16]));
    assign child     = side ? r_ch[31:16] : r_ch[15:0];

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_res       = r_res;
        n_px        = r_px;
        n_py        = r_py;
        n_steps     = r_steps;
        n_ox        = ox;
        n_oy        = oy;
        n_dxh       = nd.dx[31:16];
        n_dyh       = nd.dy[31:16];
        n_ch        = {nd.back, nd.front};
        n_left      = r_dyh * r_ox;
        n_right     = r_oy * r_dxh;
        n_early     = 1'b1;
        n_eside     = 1'b0;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = i_head.addr;

        if (nd.dx == '0) begin
            n_eside = (r_px <= nd.x) ? (nd.dy > 0) : (nd.dy < 0);
        end else if (nd.dy == '0) begin
            n_eside = (r_py <= nd.y) ? (nd.dx < 0) : (nd.dx > 0);
        end else if (nd.dy[31] ^ nd.dx[31] ^ ox[31] ^ oy[31]) begin
            n_eside = nd.dy[31] ^ ox[31];
        end else begin
            n_early = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_px  = i_head.px;
                    n_py  = i_head.py;
                    n_steps = '0;
                    case (i_head.kind)
                        K_WRITE: wr_en = 1'b1;
                        K_QUERY: begin
                            rd_en   = 1'b1;
                            n_state = S_T1;
                        end
                        default: begin
                            n_res   = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_T1: n_state = S_T2;
            S_T2: n_state = S_T3;
            S_T3: begin
                n_steps = steps_inc;
                if (child[15]) begin
                    n_res.subsector_index = (32'(child[14:0]) >= MAX_SUBSECTORS)
                                          ? 15'(MAX_SUBSECTORS - 1) : child[14:0];
                    n_res.steps_taken     = 14'(steps_inc);
                    n_res.loop_error      = 1'b0;
                    n_state               = S_DONE;
                end else if (steps_inc == STEP_W'(MAX_NODES)) begin
                    n_res.subsector_index = '0;
                    n_res.steps_taken     = 14'(steps_inc);
                    n_res.loop_error      = 1'b1;
                    n_state               = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = child[NODE_AW-1:0];
                    n_state = S_T1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out   <= n_out;
        r_res   <= n_res;
        r_px    <= n_px;
        r_py    <= n_py;
        r_steps <= n_steps;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_dxh   <= n_dxh;
        r_dyh   <= n_dyh;
        r_ch    <= n_ch;
        r_early <= n_early;
        r_eside <= n_eside;
        r_left  <= n_left;
        r_right <= n_right;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/bsp_point_location.sv
`timescale 1ns / 1ps
// Top level of the BSP point location block.
// Depends on bspl_pkg, bspl_front, bspl_queue, bspl_back and bspl_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries transactions.
//   mode 0 writes one node table entry and gives no result; mode 1 locates a
//   point and gives exactly one result on the output channel (o_out_valid /
//   i_out_stall / o_out_data). Results come in input order.
//   i_cfg_wr_en / i_cfg_wr_data load node_count; write it only while idle.
//   A query waits in the input register and queue, then passes through
//   states S_T1, S_T2 and S_T3 for each node tested (node RAM read, side
//   test setup, multiply and compare), then goes to the output register.
//   An empty table query skips the walk. A write is done in the walker's
//   idle state, so writes stream at one per cycle while the walker is idle.
//   A two-entry queue lets the front keep taking transactions while a walk
//   runs. When i_out_stall holds, the finished result waits in the output
//   register and in the walker; the queue then fills and o_in_stall rises.
//   Reset (synchronous, active low) empties the pipeline and clears
//   node_count; the node table contents are undefined until written.
module bsp_point_location
    import bspl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data
);

    logic q_push;
    t_cmd q_push_data;
    logic q_full;
    logic q_pop;
    t_cmd q_head;
    logic q_empty;

    bspl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (q_push),
        .o_push_data   (q_push_data),
        .i_q_full      (q_full)
    );

    bspl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_empty     (q_empty)
    );

    bspl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    a_reset_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_full)
        else $error("input stalled with room in queue");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for bsp_point_location: loads node tables, locates points
// and compares every result with a tree walk kept in the bench. Depends on bspl_pkg.
module testbench;
    import bspl_pkg::*;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam int   RANDOM_ITEMS = 800;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BLOCKS
    } t_stall_kind;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in              in_data;
    logic             out_valid;
    logic             out_stall;
    t_out             out_data;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    t_node            node_tbl[MAX_NODES];
    bit               node_written[MAX_NODES];
    logic [CNT_W-1:0] node_count_m = '0;
    t_out             pending_locations[$];
    t_out             want_loc;
    int               mismatch_count = 0;
    int               burst_left = 0;
    int               sent_count = 0;

    bsp_point_location DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Which side of the partition line a point falls on: 0 front, 1 back.
    function automatic bit side_test(input logic signed [31:0] px, py, x, y, dx, dy);
        logic [31:0]        ox, oy;
        logic signed [63:0] dx_i, dy_i, ox_w, oy_w, lhs, rhs;
        if (dx == 0) return (px <= x) ? (dy > 0) : (dy < 0);
        if (dy == 0) return (py <= y) ? (dx < 0) : (dx > 0);
        ox = px - x;
        oy = py - y;
        if ((dy[31] ^ dx[31] ^ ox[31] ^ oy[31]) == 1'b1) return dy[31] ^ ox[31];
        dx_i = dx;
        dy_i = dy;
        dx_i = dx_i >>> 16;
        dy_i = dy_i >>> 16;
        ox_w = $signed(ox);
        oy_w = $signed(oy);
        lhs = (dy_i * ox_w) >>> 16;
        rhs = (oy_w * dx_i) >>> 16;
        return (rhs < lhs) ? 1'b0 : 1'b1;
    endfunction

    // Walks the table from the root; returns 0 if the walk would touch an unwritten node.
    function automatic bit locate_point(input logic signed [31:0] px, py, output t_out res);
        logic [NODE_AW-1:0] cur;
        logic [15:0]        child;
        int                 steps;
        bit                 side;
        res = '0;
        steps = 0;
        if (node_count_m == 0) return 1'b1;
        cur = NODE_AW'(node_count_m - 1);
        while (steps < MAX_NODES) begin
            if (!node_written[cur]) return 1'b0;
            side = side_test(px, py, node_tbl[cur].x, node_tbl[cur].y,
                             node_tbl[cur].dx, node_tbl[cur].dy);
            steps++;
            child = side ? node_tbl[cur].back : node_tbl[cur].front;
            if (child[15]) begin
                res.subsector_index = child[14:0];
                res.steps_taken = 14'(steps);
                return 1'b1;
            end
            cur = child[NODE_AW-1:0];
        end
        res.steps_taken = 14'(steps);
        res.loop_error = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] rand_fixed();
        case ($urandom_range(0, 7))
            0: return 32'sh0;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh2_0000;
            3: return $urandom << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] base,
                                                      input bit base_ok);
        if (!base_ok) return rand_fixed();
        case ($urandom_range(0, 3))
            0: return base;
            1: return base + ($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
            default: return rand_fixed();
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in item;
        item.mode          = 1'($urandom_range(0, 1));
        item.node_index    = 13'($urandom);
        item.part_x        = $urandom;
        item.part_y        = $urandom;
        item.part_dx       = $urandom;
        item.part_dy       = $urandom;
        item.front_is_leaf = 1'($urandom_range(0, 1));
        item.front_index   = 15'($urandom);
        item.back_is_leaf  = 1'($urandom_range(0, 1));
        item.back_index    = 15'($urandom);
        item.point_x       = $urandom;
        item.point_y       = $urandom;
        return item;
    endfunction

    // Inner children only point to lower indices, so random trees never cycle.
    function automatic logic [15:0] child_ref(input int idx);
        int target;
        if (idx == 0 || $urandom_range(0, 99) < 20) return {1'b1, 15'($urandom)};
        target = $urandom_range(0, 1) ? idx - 1 : $urandom_range(0, idx - 1);
        return {1'b0, 15'(target + MAX_NODES * $urandom_range(0, 3))};
    endfunction

    function automatic t_in make_node(input int idx);
        t_in item;
        item = rand_item();
        item.mode = MODE_WRITE;
        item.node_index = 13'(idx);
        item.part_x = rand_fixed();
        item.part_y = rand_fixed();
        item.part_dx = rand_fixed();
        item.part_dy = rand_fixed();
        {item.front_is_leaf, item.front_index} = child_ref(idx);
        {item.back_is_leaf, item.back_index} = child_ref(idx);
        return item;
    endfunction

    task automatic send_item(input t_in item);
        t_out loc;
        bit   ok;
        int   gap;
        ok = 1'b1;
        loc = '0;
        if (item.mode == MODE_QUERY) ok = locate_point(item.point_x, item.point_y, loc);
        if (!ok) return;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
        if (item.mode == MODE_WRITE) begin
            node_tbl[item.node_index] = '{
                back:  {item.back_is_leaf, item.back_index},
                front: {item.front_is_leaf, item.front_index},
                dy:    item.part_dy,
                dx:    item.part_dx,
                y:     item.part_y,
                x:     item.part_x
            };
            node_written[item.node_index] = 1'b1;
        end else begin
            pending_locations.push_back(loc);
        end
    endtask

    task automatic write_node(input int idx, input logic signed [31:0] x, y, dx, dy,
                              input logic fl, input logic [14:0] fi,
                              input logic bl, input logic [14:0] bi);
        t_in item;
        item = rand_item();
        item.mode = MODE_WRITE;
        item.node_index = 13'(idx);
        item.part_x = x;
        item.part_y = y;
        item.part_dx = dx;
        item.part_dy = dy;
        item.front_is_leaf = fl;
        item.front_index = fi;
        item.back_is_leaf = bl;
        item.back_index = bi;
        send_item(item);
    endtask

    task automatic query_point(input logic signed [31:0] px, py);
        t_in item;
        item = rand_item();
        item.mode = MODE_QUERY;
        item.point_x = px;
        item.point_y = py;
        send_item(item);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_locations.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_node_count(input logic [CNT_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        node_count_m = value;
    endtask

    task automatic test_empty_table();
        query_point(rand_fixed(), rand_fixed());
        set_node_count('0);
        query_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    endtask

    task automatic test_side_rules();
        // vertical partition
        write_node(0, 32'sh1_0000, 32'sh0, 32'sh0, 32'sh1_0000, 1'b1, 15'h7FFF, 1'b1, 15'h0001);
        set_node_count(14'd1);
        query_point(32'sh0_8000, 32'sh0);
        query_point(32'sh1_0000, 32'sh5_0000);
        query_point(32'sh2_0000, -32'sh5_0000);
        // horizontal partition
        write_node(0, 32'sh0, 32'sh3_0000, -32'sh1_0000, 32'sh0, 1'b1, 15'h7FFF, 1'b1, 15'h0001);
        query_point(32'sh7_0000, 32'sh3_0000);
        query_point(-32'sh7_0000, 32'sh4_0000);
        // general line: sign shortcut, equal products, strict compare
        write_node(0, 32'sh0, 32'sh0, 32'sh3_0000, 32'sh2_0000, 1'b1, 15'h7FFF, 1'b1, 15'h0001);
        query_point(-32'sh5_0000, 32'sh7_0000);
        query_point(32'sh3_0000, 32'sh2_0000);
        query_point(32'sh4_0000, 32'sh1_0000);
        // extreme values, wrapping offsets
        write_node(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   1'b1, 15'h7FFF, 1'b1, 15'h0001);
        query_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        query_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    task automatic test_index_wrap();
        write_node(0, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
                   1'b1, 15'h1234, 1'b1, 15'h7FFF);
        write_node(MAX_NODES - 1, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
                   1'b0, 15'd8192, 1'b0, 15'd24576);
        write_node(MAX_NODES - 2, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
                   1'b0, 15'd16383, 1'b1, 15'h5555);
        set_node_count(14'd8192);
        query_point(rand_fixed(), rand_fixed());
        set_node_count(14'h3FFF);
        query_point(rand_fixed(), rand_fixed());
        query_point(rand_fixed(), rand_fixed());
    endtask

    task automatic test_walk_limit();
        write_node(0, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
                   1'b0, 15'd8192, 1'b0, 15'd0);
        set_node_count(14'd1);
        query_point(rand_fixed(), rand_fixed());
        write_node(1, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
                   1'b0, 15'd0, 1'b0, 15'd24576);
        write_node(0, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
                   1'b0, 15'd1, 1'b0, 15'd1);
        set_node_count(14'd2);
        query_point(rand_fixed(), rand_fixed());
    endtask

    task automatic test_random_trees();
        int                 start;
        int                 n;
        int                 nq;
        int                 pick;
        logic [NODE_AW-1:0] root;
        logic [CNT_W-1:0]   count;
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 160) : $urandom_range(1, 48);
            for (int i = 0; i < n; i++) send_item(make_node(i));
            count = CNT_W'(n);
            if ($urandom_range(0, 5) == 0) count = CNT_W'(n + MAX_NODES);
            set_node_count(count);
            root = NODE_AW'(count - 1);
            nq = $urandom_range(15, 50);
            repeat (nq) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    send_item(make_node($urandom_range(0, n - 1)));
                end else if (pick < 15) begin
                    send_item(make_node($urandom_range(n, MAX_NODES - 3)));
                end else begin
                    query_point(pick_coord(node_tbl[root].x, node_written[root]),
                                pick_coord(node_tbl[root].y, node_written[root]));
                end
            end
        end
        set_node_count('0);
        query_point(rand_fixed(), rand_fixed());
    endtask

    initial begin
        t_stall_kind stall_kind;
        int          stretch;
        int          hold;
        out_stall = 1'b0;
        hold = 0;
        forever begin
            stall_kind = t_stall_kind'($urandom_range(0, 3));
            stretch = $urandom_range(20, 200);
            repeat (stretch) begin
                @(negedge clk);
                case (stall_kind)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                    default: begin
                        if (hold == 0) begin
                            hold = $urandom_range(1, 30);
                            out_stall <= ~out_stall;
                        end
                        hold--;
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_locations.size() == 0) begin
                $error("unexpected result transaction: subsector_index %0d",
                       out_data.subsector_index);
                mismatch_count++;
            end else begin
                want_loc = pending_locations.pop_front();
                if (out_data.subsector_index !== want_loc.subsector_index) begin
                    $error("subsector_index expected %0d actual %0d",
                           want_loc.subsector_index, out_data.subsector_index);
                    mismatch_count++;
                end
                if (out_data.steps_taken !== want_loc.steps_taken) begin
                    $error("steps_taken expected %0d actual %0d",
                           want_loc.steps_taken, out_data.steps_taken);
                    mismatch_count++;
                end
                if (out_data.loop_error !== want_loc.loop_error) begin
                    $error("loop_error expected %0d actual %0d",
                           want_loc.loop_error, out_data.loop_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_side_rules();
        test_index_wrap();
        test_walk_limit();
        test_random_trees();

        wait_idle();
        repeat (50) @(posedge clk);
        if (pending_locations.size() != 0) begin
            $error("%0d result transactions never arrived", pending_locations.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
